// ===== src/lsnp_pkg.sv =====
// Shared types and constants of the scan node parser.
// Used by the framer, the node queue, the decoder and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lsnp_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_ENABLE     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUALITY_MIN     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_MIN_MM = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_MAX_MM = 8'd3;

    localparam logic [13:0] DISTANCE_MAX_RESET = 14'd16383;

    typedef struct packed {
        logic [7:0]         sync_byte;
        logic [7:0]         angle_lo;
        logic [7:0]         angle_hi;
        logic [7:0]         dist_lo;
        logic [7:0]         dist_hi;
        logic signed [15:0] pose_x_cm;
        logic signed [15:0] pose_y_cm;
        logic signed [31:0] heading_q8;
    } node_t;

    typedef struct packed {
        logic       scan_enable;
        logic [5:0] quality_min;
        logic [13:0] distance_min_mm;
        logic [13:0] distance_max_mm;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/lidar_scan_node_parser_unit.sv =====
// Top level of the scan node parser: configuration registers, framer, node queue, decoder.
// Depends on lsnp_pkg, lsnp_front, lsnp_queue and lsnp_back.
//
//   Channel   Signals                                  Direction
//   bytes     in_valid / in_stall, rx_byte, pose       in
//   nodes     out_valid / out_stall, decoded record    out
//   config    cfg_write_en, cfg_index, cfg_data        in
//
// One byte is taken every cycle unless the queue is full; a node is queued, then registered.
// The framer and the output register each run at one beat a cycle; the queue absorbs stalls.
// Bytes are stalled only while the node queue is full.
// Reset clears the framer, the queue and the configuration; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lidar_scan_node_parser_unit
    import lsnp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             rx_byte,
    input  wire logic signed [15:0]     pose_x_cm,
    input  wire logic signed [15:0]     pose_y_cm,
    input  wire logic signed [31:0]     heading_q8,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [16:0]                 angle_q8,
    output logic [13:0]                 range_mm,
    output logic [5:0]                  quality,
    output logic signed [15:0]          out_x_cm,
    output logic signed [15:0]          out_y_cm,
    output logic signed [31:0]          out_heading_q8,
    output logic [7:0]                  check_xor,
    output logic                        new_revolution,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg_reg;
    logic  restart;
    logic  byte_accept;
    logic  push;
    node_t push_node;
    logic  pop;
    logic  queue_full;
    logic  queue_not_empty;
    node_t head_node;

    assign restart     = cfg_write_en && (cfg_index == REG_SCAN_ENABLE) && cfg_data[0];
    assign in_stall    = queue_full;
    assign byte_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_enable     <= 1'b0;
            cfg_reg.quality_min     <= '0;
            cfg_reg.distance_min_mm <= '0;
            cfg_reg.distance_max_mm <= DISTANCE_MAX_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_SCAN_ENABLE:     cfg_reg.scan_enable     <= cfg_data[0];
                REG_QUALITY_MIN:     cfg_reg.quality_min     <= cfg_data[5:0];
                REG_DISTANCE_MIN_MM: cfg_reg.distance_min_mm <= cfg_data[13:0];
                REG_DISTANCE_MAX_MM: cfg_reg.distance_max_mm <= cfg_data[13:0];
                default:             ;
            endcase
        end
    end

    lsnp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .scan_enable (cfg_reg.scan_enable),
        .byte_accept (byte_accept),
        .rx_byte     (rx_byte),
        .pose_x_cm   (pose_x_cm),
        .pose_y_cm   (pose_y_cm),
        .heading_q8  (heading_q8),
        .push        (push),
        .push_node   (push_node)
    );

    lsnp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_node (push_node),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_node (head_node)
    );

    lsnp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .node_ready     (queue_not_empty),
        .node           (head_node),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_q8       (angle_q8),
        .range_mm       (range_mm),
        .quality        (quality),
        .out_x_cm       (out_x_cm),
        .out_y_cm       (out_y_cm),
        .out_heading_q8 (out_heading_q8),
        .check_xor      (check_xor),
        .new_revolution (new_revolution)
    );

endmodule

`default_nettype wire

// ===== src/lsnp_front.sv =====
// Byte framer: collects five-byte scan nodes and pushes each complete one to the queue.
// Depends on lsnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsnp_front
    import lsnp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               restart,
    input  wire logic               scan_enable,
    input  wire logic               byte_accept,
    input  wire logic [7:0]         rx_byte,
    input  wire logic signed [15:0] pose_x_cm,
    input  wire logic signed [15:0] pose_y_cm,
    input  wire logic signed [31:0] heading_q8,
    output logic                    push,
    output node_t                   push_node
);

    typedef enum logic [2:0] {
        POS_SYNC,
        POS_ANGLE_LO,
        POS_ANGLE_HI,
        POS_DIST_LO,
        POS_DIST_HI
    } pos_t;

    pos_t       pos_reg;
    pos_t       pos_next;
    logic [7:0] sync_byte_reg;
    logic [7:0] angle_lo_reg;
    logic [7:0] angle_hi_reg;
    logic [7:0] dist_lo_reg;
    logic       take;

    assign take = byte_accept && scan_enable;

    always_comb
    begin
        pos_next = pos_reg;
        push     = 1'b0;
        if (take)
        begin
            case (pos_reg)
                POS_SYNC:     pos_next = (rx_byte[0] ^ rx_byte[1]) ? POS_ANGLE_LO : POS_SYNC;
                POS_ANGLE_LO: pos_next = rx_byte[0] ? POS_ANGLE_HI : POS_SYNC;
                POS_ANGLE_HI: pos_next = POS_DIST_LO;
                POS_DIST_LO:  pos_next = POS_DIST_HI;
                POS_DIST_HI:
                begin
                    pos_next = POS_SYNC;
                    push     = 1'b1;
                end
                default:      pos_next = POS_SYNC;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_SYNC;
        end
        else if (restart)
        begin
            pos_reg <= POS_SYNC;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            case (pos_reg)
                POS_SYNC:     sync_byte_reg <= rx_byte;
                POS_ANGLE_LO: angle_lo_reg  <= rx_byte;
                POS_ANGLE_HI: angle_hi_reg  <= rx_byte;
                POS_DIST_LO:  dist_lo_reg   <= rx_byte;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        push_node.sync_byte  = sync_byte_reg;
        push_node.angle_lo   = angle_lo_reg;
        push_node.angle_hi   = angle_hi_reg;
        push_node.dist_lo    = dist_lo_reg;
        push_node.dist_hi    = rx_byte;
        push_node.pose_x_cm  = pose_x_cm;
        push_node.pose_y_cm  = pose_y_cm;
        push_node.heading_q8 = heading_q8;
    end

    a_push_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (pos_reg == POS_DIST_HI) && scan_enable)
        else $error("node pushed outside the last byte position");

    a_push_returns_to_sync: assert property (@(posedge clk) disable iff (!rst_n)
        push && !restart |=> pos_reg == POS_SYNC)
        else $error("framer did not return to the sync position after a node");

    a_angle_check_bit: assert property (@(posedge clk) disable iff (!rst_n)
        take && !restart && (pos_reg == POS_ANGLE_LO) && !rx_byte[0] |=> pos_reg == POS_SYNC)
        else $error("framer kept a node whose check bit was clear");

endmodule

`default_nettype wire

// ===== src/lsnp_queue.sv =====
// Short first-in first-out queue of complete scan nodes between framer and decoder.
// Depends on lsnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsnp_queue
    import lsnp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire node_t push_node,
    input  wire logic  pop,
    output logic       full,
    output logic       not_empty,
    output node_t      head_node
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    node_t              slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_node = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_node;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("node pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("node taken from an empty queue");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("queue count beyond its depth");

endmodule

`default_nettype wire

// ===== src/lsnp_back.sv =====
// Node decoder: extracts angle, distance and quality, applies the filters, builds the
// checksum and holds the result in the output register. Depends on lsnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsnp_back
    import lsnp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                node_ready,
    input  wire node_t               node,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [16:0]              angle_q8,
    output logic [13:0]              range_mm,
    output logic [5:0]               quality,
    output logic signed [15:0]       out_x_cm,
    output logic signed [15:0]       out_y_cm,
    output logic signed [31:0]       out_heading_q8,
    output logic [7:0]               check_xor,
    output logic                     new_revolution
);

    logic               valid_reg;
    logic [16:0]        angle_reg;
    logic [13:0]        dist_reg;
    logic [5:0]         quality_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic signed [31:0] heading_reg;
    logic [7:0]         xor_reg;
    logic               sync_reg;

    logic               can_load;
    logic               pass;
    logic [16:0]        angle_dec;
    logic [13:0]        dist_dec;
    logic [5:0]         quality_dec;
    logic [7:0]         xor_dec;

    assign angle_dec   = {node.angle_hi, node.angle_lo[7:1], 2'b00};
    assign dist_dec    = {node.dist_hi, node.dist_lo[7:2]};
    assign quality_dec = node.sync_byte[7:2];

    assign pass = (quality_dec >= cfg.quality_min)
               && (dist_dec <= cfg.distance_max_mm)
               && (dist_dec >= cfg.distance_min_mm);

    assign xor_dec = angle_dec[7:0] ^ angle_dec[15:8] ^ {7'd0, angle_dec[16]}
                   ^ dist_dec[7:0] ^ {2'd0, dist_dec[13:8]}
                   ^ {2'd0, quality_dec}
                   ^ node.pose_x_cm[7:0] ^ node.pose_x_cm[15:8]
                   ^ node.pose_y_cm[7:0] ^ node.pose_y_cm[15:8]
                   ^ node.heading_q8[7:0] ^ node.heading_q8[15:8]
                   ^ node.heading_q8[23:16] ^ node.heading_q8[31:24];

    assign can_load = !valid_reg || !out_stall;
    assign pop      = node_ready && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= pop && pass;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pass)
        begin
            angle_reg   <= angle_dec;
            dist_reg    <= dist_dec;
            quality_reg <= quality_dec;
            x_reg       <= node.pose_x_cm;
            y_reg       <= node.pose_y_cm;
            heading_reg <= node.heading_q8;
            xor_reg     <= xor_dec;
            sync_reg    <= node.sync_byte[0];
        end
    end

    assign out_valid      = valid_reg;
    assign angle_q8       = angle_reg;
    assign range_mm       = dist_reg;
    assign quality        = quality_reg;
    assign out_x_cm       = x_reg;
    assign out_y_cm       = y_reg;
    assign out_heading_q8 = heading_reg;
    assign check_xor      = xor_reg;
    assign new_revolution = sync_reg;

    a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !valid_reg || !out_stall)
        else $error("node taken while the output register was held");

    a_filtered_node_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !pass |=> !valid_reg)
        else $error("filtered node reached the output");

    a_angle_step: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> angle_reg[1:0] == 2'b00)
        else $error("angle in the output register is not a multiple of four");

endmodule

`default_nettype wire

// ===== tb/lsnp_checker.sv =====
// Checker for the scan node parser: watches the byte, record and register ports.
// Keeps its own framer and register copy, predicts each record and compares it.
// Depends on lsnp_pkg for the register indexes, the node and the register types.
`timescale 1ns / 1ps

module lsnp_checker
    import lsnp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [7:0]             rx_byte,
    input  wire logic signed [15:0]     pose_x_cm,
    input  wire logic signed [15:0]     pose_y_cm,
    input  wire logic signed [31:0]     heading_q8,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [16:0]            angle_q8,
    input  wire logic [13:0]            range_mm,
    input  wire logic [5:0]             quality,
    input  wire logic signed [15:0]     out_x_cm,
    input  wire logic signed [15:0]     out_y_cm,
    input  wire logic signed [31:0]     out_heading_q8,
    input  wire logic [7:0]             check_xor,
    input  wire logic                   new_revolution,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          records_waiting,
    output int                          records_checked,
    output int                          mismatches
);

    typedef struct packed {
        logic [16:0]        angle_q8;
        logic [13:0]        range_mm;
        logic [5:0]         quality;
        logic signed [15:0] x_cm;
        logic signed [15:0] y_cm;
        logic signed [31:0] heading_q8;
        logic [7:0]         check_xor;
        logic               new_revolution;
    } scan_record_t;

    typedef enum logic [2:0] {
        AWAIT_SYNC,
        AWAIT_ANGLE_LO,
        AWAIT_ANGLE_HI,
        AWAIT_DIST_LO,
        AWAIT_DIST_HI
    } frame_pos_t;

    cfg_t         model_cfg;
    frame_pos_t   frame_pos;
    node_t        node;
    scan_record_t predicted_records[$];
    scan_record_t got;
    scan_record_t want;
    int           mismatch_count;
    int           checked_count;

    function automatic string record_text(scan_record_t r);
        return $sformatf("angle=%0d dist=%0d qual=%0d x=%0d y=%0d hdg=%0d xor=%02h rev=%0b",
                         r.angle_q8, r.range_mm, r.quality, r.x_cm, r.y_cm,
                         r.heading_q8, r.check_xor, r.new_revolution);
    endfunction

    task automatic frame_byte(input logic [7:0] b, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic signed [31:0] h);
        logic [15:0]  dist_raw;
        scan_record_t rec;
        if (!model_cfg.scan_enable)
            return;
        case (frame_pos)
            AWAIT_SYNC:
            begin
                if (b[0] ^ b[1])
                begin
                    node.sync_byte = b;
                    frame_pos = AWAIT_ANGLE_LO;
                end
            end
            AWAIT_ANGLE_LO:
            begin
                if (b[0])
                begin
                    node.angle_lo = b;
                    frame_pos = AWAIT_ANGLE_HI;
                end
                else
                    frame_pos = AWAIT_SYNC;
            end
            AWAIT_ANGLE_HI:
            begin
                node.angle_hi = b;
                frame_pos = AWAIT_DIST_LO;
            end
            AWAIT_DIST_LO:
            begin
                node.dist_lo = b;
                frame_pos = AWAIT_DIST_HI;
            end
            AWAIT_DIST_HI:
            begin
                frame_pos = AWAIT_SYNC;
                dist_raw = {b, node.dist_lo};
                rec.angle_q8 = {node.angle_hi, node.angle_lo[7:1], 2'b00};
                rec.range_mm = dist_raw[15:2];
                rec.quality = node.sync_byte[7:2];
                rec.x_cm = x;
                rec.y_cm = y;
                rec.heading_q8 = h;
                rec.new_revolution = node.sync_byte[0];
                rec.check_xor = rec.angle_q8[7:0] ^ rec.angle_q8[15:8]
                              ^ {7'b0, rec.angle_q8[16]}
                              ^ rec.range_mm[7:0] ^ {2'b0, rec.range_mm[13:8]}
                              ^ {2'b0, rec.quality}
                              ^ x[7:0] ^ x[15:8] ^ y[7:0] ^ y[15:8]
                              ^ h[7:0] ^ h[15:8] ^ h[23:16] ^ h[31:24];
                if (rec.quality >= model_cfg.quality_min
                    && rec.range_mm >= model_cfg.distance_min_mm
                    && rec.range_mm <= model_cfg.distance_max_mm)
                    predicted_records.push_back(rec);
            end
            default:
                frame_pos = AWAIT_SYNC;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_cfg.scan_enable = 1'b0;
            model_cfg.quality_min = '0;
            model_cfg.distance_min_mm = '0;
            model_cfg.distance_max_mm = DISTANCE_MAX_RESET;
            frame_pos = AWAIT_SYNC;
            node = '0;
            predicted_records.delete();
            mismatch_count = 0;
            checked_count = 0;
            records_waiting <= 0;
            records_checked <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_SCAN_ENABLE:
                    begin
                        model_cfg.scan_enable = cfg_data[0];
                        if (cfg_data[0])
                            frame_pos = AWAIT_SYNC;
                    end
                    REG_QUALITY_MIN:     model_cfg.quality_min = cfg_data[5:0];
                    REG_DISTANCE_MIN_MM: model_cfg.distance_min_mm = cfg_data[13:0];
                    REG_DISTANCE_MAX_MM: model_cfg.distance_max_mm = cfg_data[13:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                frame_byte(rx_byte, pose_x_cm, pose_y_cm, heading_q8);

            if (out_valid && !out_stall)
            begin
                got.angle_q8 = angle_q8;
                got.range_mm = range_mm;
                got.quality = quality;
                got.x_cm = out_x_cm;
                got.y_cm = out_y_cm;
                got.heading_q8 = out_heading_q8;
                got.check_xor = check_xor;
                got.new_revolution = new_revolution;
                if (predicted_records.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: record beat with none predicted: %s",
                                 $realtime, record_text(got));
                end
                else
                begin
                    want = predicted_records.pop_front();
                    checked_count++;
                    if (got.angle_q8 !== want.angle_q8
                        || got.range_mm !== want.range_mm
                        || got.quality !== want.quality
                        || got.x_cm !== want.x_cm
                        || got.y_cm !== want.y_cm
                        || got.heading_q8 !== want.heading_q8
                        || got.check_xor !== want.check_xor
                        || got.new_revolution !== want.new_revolution)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: record %0d differs", $realtime, checked_count);
                            $display("    expected %s", record_text(want));
                            $display("    actual   %s", record_text(got));
                        end
                    end
                end
            end

            records_waiting <= predicted_records.size();
            records_checked <= checked_count;
            mismatches <= mismatch_count;
        end
    end

endmodule

// ===== tb/lidar_scan_node_parser_unit_tb.sv =====
// Top of the scan node parser testbench: clock, reset, byte and register stimulus, verdict.
// Instantiates lidar_scan_node_parser_unit and lsnp_checker; depends on lsnp_pkg.
`timescale 1ns / 1ps

module lidar_scan_node_parser_unit_tb;
    import lsnp_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BEATS  = 64;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             rx_byte;
    logic signed [15:0]     pose_x_cm;
    logic signed [15:0]     pose_y_cm;
    logic signed [31:0]     heading_q8;
    logic                   out_valid;
    logic                   out_stall;
    logic [16:0]            angle_q8;
    logic [13:0]            range_mm;
    logic [5:0]             quality;
    logic signed [15:0]     out_x_cm;
    logic signed [15:0]     out_y_cm;
    logic signed [31:0]     out_heading_q8;
    logic [7:0]             check_xor;
    logic                   new_revolution;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int records_waiting;
    int records_checked;
    int mismatches;
    int cycle_count;
    int bytes_sent;
    int phases_run;
    bit quiet;
    bit scan_on;

    lidar_scan_node_parser_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .pose_x_cm      (pose_x_cm),
        .pose_y_cm      (pose_y_cm),
        .heading_q8     (heading_q8),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_q8       (angle_q8),
        .range_mm       (range_mm),
        .quality        (quality),
        .out_x_cm       (out_x_cm),
        .out_y_cm       (out_y_cm),
        .out_heading_q8 (out_heading_q8),
        .check_xor      (check_xor),
        .new_revolution (new_revolution),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    lsnp_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .pose_x_cm       (pose_x_cm),
        .pose_y_cm       (pose_y_cm),
        .heading_q8      (heading_q8),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .angle_q8        (angle_q8),
        .range_mm        (range_mm),
        .quality         (quality),
        .out_x_cm        (out_x_cm),
        .out_y_cm        (out_y_cm),
        .out_heading_q8  (out_heading_q8),
        .check_xor       (check_xor),
        .new_revolution  (new_revolution),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .records_waiting (records_waiting),
        .records_checked (records_checked),
        .mismatches      (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped after %0d cycles with %0d records outstanding.",
                 cycle_count, records_waiting);
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        int hold;
        out_stall <= 1'b1;
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 12);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [31:0] h);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        pose_x_cm <= x;
        pose_y_cm <= y;
        heading_q8 <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_node(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                             input logic [7:0] b3, input logic [7:0] b4,
                             input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [31:0] h);
        send_byte(b0, 16'($urandom), 16'($urandom), 32'($urandom));
        send_byte(b1, 16'($urandom), 16'($urandom), 32'($urandom));
        send_byte(b2, 16'($urandom), 16'($urandom), 32'($urandom));
        send_byte(b3, 16'($urandom), 16'($urandom), 32'($urandom));
        send_byte(b4, x, y, h);
    endtask

    task automatic send_scan_node(input logic [5:0] q_floor, input logic [13:0] d_lo,
                                  input logic [13:0] d_hi);
        logic [5:0]  qual;
        logic [13:0] dist_mm;
        logic [15:0] dist_raw;
        logic [14:0] angle;
        logic        sync;
        qual = $urandom_range(0, 1) ? 6'($urandom_range(q_floor, 63)) : 6'($urandom);
        dist_mm = ($urandom_range(0, 1) && d_lo <= d_hi) ? 14'($urandom_range(d_lo, d_hi))
                                                         : 14'($urandom);
        sync = 1'($urandom);
        angle = 15'($urandom);
        dist_raw = {dist_mm, 2'($urandom)};
        send_node({qual, ~sync, sync}, {angle[6:0], 1'b1}, angle[14:7],
                  dist_raw[7:0], dist_raw[15:8],
                  16'($urandom), 16'($urandom), 32'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (records_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic en, input logic [5:0] q_min,
                                input logic [13:0] d_min, input logic [13:0] d_max);
        logic [CFG_DATA_W-1:0] junk;
        wait_idle();
        junk = 14'($urandom);
        write_reg(REG_QUALITY_MIN, {junk[13:6], q_min});
        write_reg(REG_DISTANCE_MIN_MM, d_min);
        write_reg(REG_DISTANCE_MAX_MM, d_max);
        if (en != scan_on || $urandom_range(0, 1))
        begin
            write_reg(REG_SCAN_ENABLE, {junk[13:1], en});
            scan_on = en;
        end
        phases_run++;
    endtask

    initial
    begin
        logic        en;
        logic [5:0]  q_min;
        logic [13:0] d_min;
        logic [13:0] d_max;
        logic        sync;
        int          pick;
        int          beats;
        int          target;

        quiet = 1'b0;
        scan_on = 1'b0;
        bytes_sent = 0;
        phases_run = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= '0;
        pose_x_cm <= '0;
        pose_y_cm <= '0;
        heading_q8 <= '0;
        cfg_write_en <= 1'b0;
        cfg_index <= REG_SCAN_ENABLE;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed beats: extreme nodes, rejected sync bytes and a bad check bit.
        apply_config(1'b1, 6'd0, 14'd0, DISTANCE_MAX_RESET);
        send_node(8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'sh7FFF, 16'sh7FFF, 32'sh7FFFFFFF);
        send_node(8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 16'sh8000, 16'sh8000, 32'sh80000000);
        send_byte(8'h00, 16'($urandom), 16'($urandom), 32'($urandom));
        send_byte(8'h03, 16'($urandom), 16'($urandom), 32'($urandom));
        send_byte(8'hFF, 16'($urandom), 16'($urandom), 32'($urandom));
        send_node(8'h01, 8'h81, 8'h5A, 8'hA5, 8'h3C, 16'sh0000, 16'shFFFF, 32'sh00000000);
        send_byte(8'h01, 16'($urandom), 16'($urandom), 32'($urandom));
        send_byte(8'h02, 16'($urandom), 16'($urandom), 32'($urandom));
        send_node(8'h86, 8'h55, 8'hAA, 8'hFC, 8'hFF, 16'sh1234, -16'sd1, -32'sd1);

        // Bytes while scanning is off, then a write to an unused register index.
        apply_config(1'b0, 6'd0, 14'd0, DISTANCE_MAX_RESET);
        send_node(8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'sh7FFF, 16'sh7FFF, 32'sh7FFFFFFF);
        wait_idle();
        write_reg(8'($urandom_range(4, 255)), 14'($urandom));

        for (int p = 0; p < 10; p++)
        begin
            en = 1'b1;
            q_min = 6'd0;
            d_min = 14'd0;
            d_max = 14'd16383;
            case (p)
                1: q_min = 6'd63;
                2: d_min = 14'd16383;
                3: d_max = 14'd0;
                4: en = 1'b0;
                5:
                begin
                    d_min = 14'd12000;
                    d_max = 14'd3000;
                end
                6, 7, 8, 9:
                begin
                    q_min = 6'($urandom_range(0, 63));
                    d_min = 14'($urandom_range(0, 8000));
                    d_max = 14'($urandom_range(d_min, 16383));
                end
                default: ;
            endcase
            apply_config(en, q_min, d_min, d_max);
            quiet = (p % 3 == 1);
            target = en ? PHASE_BEATS : 20;
            beats = 0;
            while (beats < target)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 15)
                begin
                    send_scan_node(q_min, d_min, d_max);
                    beats += 5;
                end
                else if (pick < 18)
                begin
                    send_byte(8'($urandom), 16'($urandom), 16'($urandom), 32'($urandom));
                    beats += 1;
                end
                else
                begin
                    sync = 1'($urandom);
                    send_byte({6'($urandom), ~sync, sync},
                              16'($urandom), 16'($urandom), 32'($urandom));
                    send_byte({7'($urandom), 1'b0},
                              16'($urandom), 16'($urandom), 32'($urandom));
                    beats += 2;
                end
            end
        end

        quiet = 1'b0;
        wait_idle();
        @(posedge clk);
        $display("Sent %0d byte beats across %0d register settings; %0d node records compared.",
                 bytes_sent, phases_run, records_checked);
        $display("Settings included the quality and distance extremes, an empty window and"
                 , " scanning switched off.");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== lidar_scan_node_parser_unit.f =====
src/lsnp_pkg.sv
src/lsnp_front.sv
src/lsnp_queue.sv
src/lsnp_back.sv
src/lidar_scan_node_parser_unit.sv
tb/lsnp_checker.sv
tb/lidar_scan_node_parser_unit_tb.sv
